/* src/ldgf_pkg.sv */
// ----------------------------------------------------------------------------
// ldgf_pkg
// Shared types, constants and command/status groups of the door gap filter.
// ----------------------------------------------------------------------------
package ldgf_pkg;

  localparam int MAX_PEAKS = 16;
  localparam int MAX_DOORS = 16;
  localparam int PCNT_W    = $clog2(MAX_PEAKS + 1);
  localparam int PIDX_W    = $clog2(MAX_PEAKS);
  localparam int DCNT_W    = $clog2(MAX_DOORS + 1);
  localparam int DIDX_W    = $clog2(MAX_DOORS);
  localparam int CNT_W     = (PCNT_W > DCNT_W) ? PCNT_W : DCNT_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_JUMP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_W    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd4;

  localparam logic [15:0] JUMP_RST     = 16'd1000;
  localparam logic [15:0] SUPPRESS_RST = 16'd500;
  localparam logic [15:0] MIN_W_RST    = 16'd800;
  localparam logic [15:0] MAX_W_RST    = 16'd1200;
  localparam logic [11:0] MARGIN_RST   = 12'd200;

  typedef enum logic [1:0] {
    KIND_DOOR    = 2'd0,
    KIND_VERDICT = 2'd1,
    KIND_NODOOR  = 2'd2
  } kind_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_FILTER = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    DS_SUPP,
    DS_PAIR,
    DS_COVER
  } dsel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_PAIR_LOAD,
    ST_PAIR_SCAN,
    ST_EMIT,
    ST_FILTER
  } ctrl_state_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [12:0] a;
  } pt_t;

  typedef struct packed {
    pt_t e1;
    pt_t e0;
  } door_t;

  typedef struct packed {
    logic        op;
    pt_t         pt;
    logic [15:0] range;
    logic        eos;
  } in_item_t;

  typedef struct packed {
    kind_t kind;
    door_t door;
    logic  keep;
    logic  last;
    logic  ovf;
  } out_item_t;

  typedef struct packed {
    logic  accept;
    logic  idx_next;
    logic  peak_push;
    logic  peak_ovf;
    logic  pair_init;
    logic  pair_load;
    logic  j_next;
    logic  door_push;
    logic  door_ovf;
    logic  scan_end;
    logic  out_load;
    kind_t out_kind;
    dsel_t dsel;
  } cmd_t;

  typedef struct packed {
    logic jump;
    logic eos;
    logic i_end;
    logic supp_hit;
    logic pair_done;
    logic j_end;
    logic gap_ok;
    logic peak_full;
    logic door_full;
    logic door_none;
    logic k_end;
    logic k_last;
    logic covered;
    logic out_free;
  } sts_t;

endpackage

/* src/ldgf_ctrl.sv */
// ----------------------------------------------------------------------------
// ldgf_ctrl
// Sequencer for peak suppression, pair search, door emission and filtering.
// ----------------------------------------------------------------------------
module ldgf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_ready,
  input  ldgf_pkg::sts_t sts,
  output ldgf_pkg::cmd_t cmd
);
  import ldgf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.out_kind = KIND_DOOR;
    cmd.dsel     = DS_SUPP;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_op == OP_FILTER) ? ST_FILTER : ST_PEAK;
        end
      end
      ST_PEAK: begin
        cmd.dsel = DS_SUPP;
        if (!sts.jump || sts.i_end || sts.supp_hit) begin
          if (sts.jump && sts.i_end) begin
            cmd.peak_ovf  = sts.peak_full;
            cmd.peak_push = !sts.peak_full;
          end
          if (sts.eos) begin
            cmd.pair_init = 1'b1;
            state_nxt     = ST_PAIR_LOAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.idx_next = 1'b1;
        end
      end
      ST_PAIR_LOAD: begin
        if (sts.pair_done) begin
          cmd.scan_end = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.pair_load = 1'b1;
          state_nxt     = ST_PAIR_SCAN;
        end
      end
      ST_PAIR_SCAN: begin
        cmd.dsel = DS_PAIR;
        if (sts.j_end) begin
          cmd.idx_next = 1'b1;
          state_nxt    = ST_PAIR_LOAD;
        end else begin
          cmd.j_next = 1'b1;
          if (sts.gap_ok) begin
            cmd.door_ovf  = sts.door_full;
            cmd.door_push = !sts.door_full;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.door_none) begin
            cmd.out_kind = KIND_NODOOR;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.out_kind = KIND_DOOR;
            cmd.idx_next = 1'b1;
            if (sts.k_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_FILTER: begin
        cmd.dsel = DS_COVER;
        if (sts.k_end || sts.covered) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = KIND_VERDICT;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.idx_next = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE))
    else $error("input ready outside idle");
  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.peak_push && cmd.door_push))
    else $error("peak and door push together");
  a_emit_after_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && (state_nxt == ST_EMIT) |-> !cmd.out_load || !sts.k_last)
    else $error("emission continues past last door");
`endif

endmodule

/* src/ldgf_dp.sv */
// ----------------------------------------------------------------------------
// ldgf_dp
// Configuration, point history, peak and door stores, distance unit, output
// register.
// ----------------------------------------------------------------------------
module ldgf_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ldgf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ldgf_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  input  ldgf_pkg::in_item_t               in_item,
  input  ldgf_pkg::cmd_t                   cmd,
  output ldgf_pkg::sts_t                   sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output ldgf_pkg::out_item_t              out_item
);
  import ldgf_pkg::*;

  logic [15:0] jump_thr_r, supp_r, min_w_r, max_w_r;
  logic [11:0] margin_r;

  pt_t         prev_pt_r;
  logic [15:0] prev_range_r;
  logic        prev_valid_r;

  pt_t         cand_r;
  logic        jump_r, eos_r;
  logic [12:0] qa_r;
  logic [15:0] qrange_r;

  pt_t         peak_r [MAX_PEAKS];
  door_t       door_r [MAX_DOORS];
  logic [PCNT_W-1:0] peak_cnt_r;
  logic [DCNT_W-1:0] door_cnt_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  idx_r;
  logic [PCNT_W-1:0] j_r;
  pt_t               pi_r;

  logic      out_valid_r;
  out_item_t out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_thr_r <= JUMP_RST;
      supp_r     <= SUPPRESS_RST;
      min_w_r    <= MIN_W_RST;
      max_w_r    <= MAX_W_RST;
      margin_r   <= MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_JUMP:     jump_thr_r <= cfg_wdata;
        CFG_SUPPRESS: supp_r     <= cfg_wdata;
        CFG_MIN_W:    min_w_r    <= cfg_wdata;
        CFG_MAX_W:    max_w_r    <= cfg_wdata;
        CFG_MARGIN:   margin_r   <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // jump detection on the incoming point
  logic [15:0] rdiff;
  logic        jump_in;
  assign rdiff   = (in_item.range > prev_range_r) ? (in_item.range - prev_range_r)
                                                  : (prev_range_r - in_item.range);
  assign jump_in = prev_valid_r && (rdiff > jump_thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      prev_pt_r    <= '0;
      prev_range_r <= '0;
    end else if (cmd.accept && (in_item.op == OP_LOAD)) begin
      prev_valid_r <= !in_item.eos;
      prev_pt_r    <= in_item.pt;
      prev_range_r <= in_item.range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cand_r   <= (in_item.range < prev_range_r) ? in_item.pt : prev_pt_r;
      jump_r   <= jump_in && (in_item.op == OP_LOAD);
      eos_r    <= in_item.eos;
      qa_r     <= in_item.pt.a;
      qrange_r <= in_item.range;
    end
  end

  // shared squared-distance unit
  pt_t              pa, pb;
  door_t            dk;
  logic signed [16:0] ux, uy;
  logic signed [33:0] pxx, pyy;
  logic [33:0]      sq_sum;

  assign dk = door_r[idx_r[DIDX_W-1:0]];

  always_comb begin
    pa = cand_r;
    pb = peak_r[idx_r[PIDX_W-1:0]];
    unique case (cmd.dsel)
      DS_SUPP: begin
        pa = cand_r;
        pb = peak_r[idx_r[PIDX_W-1:0]];
      end
      DS_PAIR: begin
        pa = pi_r;
        pb = peak_r[j_r[PIDX_W-1:0]];
      end
      default: begin
        pa = dk.e0;
        pb = dk.e1;
      end
    endcase
    if (cmd.dsel == DS_COVER) begin
      ux = 17'(pa.x) + 17'(pb.x);
      uy = 17'(pa.y) + 17'(pb.y);
    end else begin
      ux = 17'(pa.x) - 17'(pb.x);
      uy = 17'(pa.y) - 17'(pb.y);
    end
  end

  assign pxx    = ux * ux;
  assign pyy    = uy * uy;
  assign sq_sum = 34'(unsigned'(pxx)) + 34'(unsigned'(pyy));

  logic [31:0] supp2, lo2, hi2, range2;
  assign supp2  = supp_r * supp_r;
  assign lo2    = min_w_r * min_w_r;
  assign hi2    = max_w_r * max_w_r;
  assign range2 = qrange_r * qrange_r;

  // angular test of the current door
  logic signed [14:0] qb, lo_a, hi_a, a1, a2, mg;
  logic               above, below, in_ang;
  assign qb     = 15'($signed(qa_r));
  assign a1     = 15'(dk.e0.a);
  assign a2     = 15'(dk.e1.a);
  assign mg     = $signed({3'b000, margin_r});
  assign lo_a   = a1 - mg;
  assign hi_a   = a2 + mg;
  assign above  = qb > lo_a;
  assign below  = qb < hi_a;
  assign in_ang = (a2 < a1) ? (above || below) : (above && below);

  // stores and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_cnt_r <= '0;
      door_cnt_r <= '0;
      ovf_r      <= 1'b0;
      idx_r      <= '0;
      j_r        <= '0;
    end else begin
      if (cmd.accept) begin
        idx_r <= '0;
        if ((in_item.op == OP_LOAD) && !prev_valid_r) begin
          ovf_r      <= 1'b0;
          peak_cnt_r <= '0;
        end
      end
      if (cmd.idx_next) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.peak_push) begin
        peak_cnt_r <= peak_cnt_r + 1'b1;
      end
      if (cmd.peak_ovf || cmd.door_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.pair_init) begin
        door_cnt_r <= '0;
        idx_r      <= '0;
      end
      if (cmd.pair_load) begin
        j_r <= PCNT_W'(idx_r) + 1'b1;
      end
      if (cmd.j_next) begin
        j_r <= j_r + 1'b1;
      end
      if (cmd.door_push) begin
        door_cnt_r <= door_cnt_r + 1'b1;
      end
      if (cmd.scan_end) begin
        peak_cnt_r <= '0;
        idx_r      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.peak_push) begin
      peak_r[peak_cnt_r[PIDX_W-1:0]] <= cand_r;
    end
    if (cmd.pair_load) begin
      pi_r <= peak_r[idx_r[PIDX_W-1:0]];
    end
    if (cmd.door_push) begin
      door_r[door_cnt_r[DIDX_W-1:0]] <= '{e0: pi_r, e1: pb};
    end
  end

  // status
  logic [CNT_W:0] idx_p1;
  assign idx_p1 = {1'b0, idx_r} + 1'b1;

  always_comb begin
    sts           = '0;
    sts.jump      = jump_r;
    sts.eos       = eos_r;
    sts.i_end     = idx_r >= CNT_W'(peak_cnt_r);
    sts.supp_hit  = sq_sum < 34'(supp2);
    sts.pair_done = idx_p1 >= (CNT_W + 1)'(peak_cnt_r);
    sts.j_end     = j_r >= peak_cnt_r;
    sts.gap_ok    = (sq_sum > 34'(lo2)) && (sq_sum < 34'(hi2));
    sts.peak_full = peak_cnt_r == PCNT_W'(MAX_PEAKS);
    sts.door_full = door_cnt_r == DCNT_W'(MAX_DOORS);
    sts.door_none = door_cnt_r == '0;
    sts.k_end     = idx_r >= CNT_W'(door_cnt_r);
    sts.k_last    = idx_p1 == (CNT_W + 1)'(door_cnt_r);
    sts.covered   = in_ang && ({range2, 2'b00} >= sq_sum);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.kind <= cmd.out_kind;
      out_r.door <= (cmd.out_kind == KIND_DOOR) ? dk : '0;
      out_r.keep <= (cmd.out_kind == KIND_VERDICT) ? sts.k_end : 1'b0;
      out_r.last <= (cmd.out_kind == KIND_DOOR) ? sts.k_last : 1'b1;
      out_r.ovf  <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_peak_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    peak_cnt_r <= PCNT_W'(MAX_PEAKS))
    else $error("peak count beyond store");
  a_door_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    door_cnt_r <= DCNT_W'(MAX_DOORS))
    else $error("door count beyond store");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while stalled");
`endif

endmodule

/* src/lidar_door_gap_filter_core.sv */
// ----------------------------------------------------------------------------
// lidar_door_gap_filter_core
// Door gap detection over a lidar scan and point filtering against the doors.
// ----------------------------------------------------------------------------
//  channel  | tdata                               | tuser       | tlast
//  in_      | point_x, point_y, bearing, range_mm | operation   | end_of_scan
//  out_     | edges, keep_point, store_overflow   | result_kind | last_result
//  cfg_     | write enable, index, 16-bit data    | -           | -
//
// A load point is accepted at the idle state; after a range jump it then walks
// the kept peaks (up to MAX_PEAKS) through the suppression check. On end of
// scan the pair search loads each peak and scans the later peaks against it,
// then emits each stored door in turn, or one no-door result.
// A filter query walks the doors until one covers it, then returns its verdict.
// The single distance unit serves all of these walks, one store read at a time.
// Reset is synchronous and needs no clearing pass; a full output register
// stalls the sequencer while the next input still waits at the idle state.
// ----------------------------------------------------------------------------
module lidar_door_gap_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ldgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ldgf_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // point_x[15:0], point_y[31:16], bearing[44:32], range_mm[60:45], zero fill
  input  logic [63:0]                    in_tdata,
  // operation
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // first_x, first_y, first_bearing, second_x, second_y, second_bearing,
  // keep_point, store_overflow from bit 0 up, zero fill to 96 bits
  output logic [95:0]                    out_tdata,
  // result_kind
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);
  import ldgf_pkg::*;

  in_item_t  in_item;
  out_item_t out_item;
  cmd_t      cmd;
  sts_t      sts;

  // unpack the input transfer
  assign in_item.op       = in_tuser;
  assign in_item.pt.x     = in_tdata[15:0];
  assign in_item.pt.y     = in_tdata[31:16];
  assign in_item.pt.a     = in_tdata[44:32];
  assign in_item.range    = in_tdata[60:45];
  assign in_item.eos      = in_tlast;

  ldgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ldgf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_item  (out_item)
  );

  // pack the result transfer
  assign out_tdata = {4'b0000, out_item.ovf, out_item.keep,
                      out_item.door.e1.a, out_item.door.e1.y, out_item.door.e1.x,
                      out_item.door.e0.a, out_item.door.e0.y, out_item.door.e0.x};
  assign out_tuser = out_item.kind;
  assign out_tlast = out_item.last;

endmodule
